// ----- rtl/core/ipbl_pkg.sv -----
// ipbl_pkg: operation codes and sequencer state type for the blocklist filter.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package ipbl_pkg;

    // operation codes carried on the op port
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT
    } state_t;

endpackage

// ----- rtl/core/ipbl_mem.sv -----
// ipbl_mem: address table storage, one write port and one registered read port.
// No package dependencies; instantiated by ip_blocklist_packet_filter_core.
`timescale 1ns / 1ps

module ipbl_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    // contents undefined until written; no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/ip_blocklist_packet_filter_core.sv -----
// ip_blocklist_packet_filter_core: blocklist table with add, remove and packet check.
// Depends on ipbl_pkg and ipbl_mem.
`timescale 1ns / 1ps

// Channel    | Signals                                   | Handshake
// -----------+-------------------------------------------+-------------------------------
// command    | op, addr_a, addr_b, header_present        | beat taken when start && !busy
// result     | ok, drop, entry_count                     | one-cycle done strobe, no stall
//
// Scan: the 32-bit compare logic walks the table, one entry per cycle, behind
// the registered memory read. Add, check and a missed remove walk every entry
// below the count before done; a duplicate add or a dropped check that hits
// ends at the hit. A remove that hits then shifts the entries above it down:
// the shift reads one entry and writes the one below each cycle. Op 3, a
// headerless check and an add to a full table are answered without a scan.
// busy is high while a scan or shift runs and is low again when the done
// strobe, which is high for one cycle, rises; a new command may start in
// that cycle. Reset clears the count and sequencer only; table entries are
// read only below the count, so no clearing pass is needed.

module ip_blocklist_packet_filter_core #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] addr_a,
    input  logic [31:0] addr_b,
    input  logic        header_present,
    output logic        done,
    output logic        ok,
    output logic        drop,
    output logic [4:0]  entry_count
);

    import ipbl_pkg::*;

    // index width for the memory, count width able to hold DEPTH itself
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    state_t          state_reg,    state_next;
    logic [CW-1:0]   count_reg,    count_next;
    logic [CW-1:0]   scan_idx_reg, scan_idx_next;   // read issue pointer
    logic            pend_reg,     pend_next;       // read data valid
    logic [AW-1:0]   pend_idx_reg, pend_idx_next;   // index of read data
    logic [1:0]      op_reg,       op_next;
    logic [31:0]     key_a_reg,    key_a_next;
    logic [31:0]     key_b_reg,    key_b_next;
    logic            done_reg,     done_next;
    logic            ok_reg,       ok_next;
    logic            drop_reg,     drop_next;

    logic            mem_wr_en;
    logic [AW-1:0]   mem_wr_addr;
    logic [31:0]     mem_wr_data;
    logic            mem_rd_en;
    logic [31:0]     mem_rd_data;

    logic            issue;
    logic            hit;
    logic            accept;
    logic [CW+4:0]   count_ext;

    ipbl_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (scan_idx_reg[AW-1:0]),
        .rd_data (mem_rd_data)
    );

    assign accept = start && (state_reg == ST_IDLE);
    assign issue  = (scan_idx_reg < count_reg);

    // shared compare unit: destination key only counts for a check
    assign hit = pend_reg &&
                 ((mem_rd_data == key_a_reg) ||
                  ((op_reg == OP_CHECK) && (mem_rd_data == key_b_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg     <= pend_next;
            done_reg     <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        op_reg       <= op_next;
        key_a_reg    <= key_a_next;
        key_b_reg    <= key_b_next;
        ok_reg       <= ok_next;
        drop_reg     <= drop_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = scan_idx_reg[AW-1:0];
        op_next       = op_reg;
        key_a_next    = key_a_reg;
        key_b_next    = key_b_reg;
        done_next     = 1'b0;
        ok_next       = ok_reg;
        drop_next     = drop_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = count_reg[AW-1:0];
        mem_wr_data   = key_a_reg;
        mem_rd_en     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next       = op;
                    key_a_next    = addr_a;
                    key_b_next    = addr_b;
                    scan_idx_next = '0;
                    ok_next       = 1'b0;
                    drop_next     = 1'b0;
                    if (((op == OP_ADD) && (count_reg < CW'(DEPTH))) ||
                        (op == OP_REMOVE) ||
                        ((op == OP_CHECK) && header_present))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        // full add, headerless check, unused code
                        done_next = 1'b1;
                    end
                end
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    if (op_reg == OP_REMOVE)
                    begin
                        // close the gap starting at the hit
                        scan_idx_next = CW'(pend_idx_reg) + CW'(1);
                        state_next    = ST_SHIFT;
                    end
                    else
                    begin
                        // duplicate add fails; check drops
                        drop_next  = (op_reg == OP_CHECK);
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (!issue && !pend_reg)
                begin
                    // whole table seen, no match
                    if (op_reg == OP_ADD)
                    begin
                        mem_wr_en  = 1'b1;
                        count_next = count_reg + CW'(1);
                        ok_next    = 1'b1;
                    end
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (issue)
                begin
                    mem_rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
            end

            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pend_idx_reg - AW'(1);
                    mem_wr_data = mem_rd_data;
                end
                if (issue)
                begin
                    mem_rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - CW'(1);
                    ok_next    = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign count_ext   = {5'd0, count_reg};
    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign ok          = ok_reg;
    assign drop        = drop_reg;
    assign entry_count = count_ext[4:0];

    // table never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above table depth");

    // an accepted beat either works on or reports at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted beat lost");

    // a result is never both success and drop
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(ok && drop))
        else $error("ok and drop both set");

    // table writes only while an operation is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (state_reg != ST_IDLE))
        else $error("table write while idle");

    // count changes only at the end of an operation
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> done)
        else $error("count changed without a result");

endmodule
